/* rtl/hmtp_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package hmtp_pkg;

  // Counter widths used when the top level is not overridden.
  localparam int unsigned COLUMN_BITS_DEF = 12;
  localparam int unsigned ROW_BITS_DEF    = 12;

  // Width of the column and row fields in a result.
  localparam int unsigned POS_W = 12;

  // Characters with a meaning of their own in the token grammar.
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_LOW_X = 8'h78;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LOW_A = 8'h61;
  localparam logic [7:0] CH_LOW_F = 8'h66;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_F  = 8'h46;

  typedef enum logic {
    OP_CHAR = 1'b0,
    OP_EOL  = 1'b1
  } hmtp_op_e;

  typedef enum logic [2:0] {
    MODE_BETWEEN = 3'd0,
    MODE_NUMBER  = 3'd1,
    MODE_COMMA   = 3'd2,
    MODE_ZERO    = 3'd3,
    MODE_HEX     = 3'd4,
    MODE_SKIP    = 3'd5
  } hmtp_mode_e;

  typedef struct packed {
    logic       operation;
    logic [7:0] ch;
  } hmtp_in_t;

  typedef struct packed {
    logic                point_valid;
    logic [POS_W-1:0]    col;
    logic [POS_W-1:0]    row;
    logic signed [31:0]  height;
    logic [31:0]         colour;
    logic                has_colour;
    logic                error;
  } hmtp_out_t;

  // Result of one parse step handed to the output register.
  typedef struct packed {
    logic      emit;
    hmtp_out_t result;
  } hmtp_step_t;

  // Hex digit decode: bit 4 is set when the byte is a hex digit.
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = '0;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= CH_LOW_A && c <= CH_LOW_F) || (c >= CH_UP_A && c <= CH_UP_F)) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* rtl/height_map_token_parser_top.sv */
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake                 Payload
// in        input      in_valid_i / in_ready_o   in_req_i  (hmtp_in_t: operation, ch)
// out       output     out_valid_o / out_ready_i out_req_o (hmtp_out_t: point, error)
//
// Each request is parsed combinationally between the input register and the output
// register, so a new request can be taken in every cycle while the output is not stalled.
// A result becomes visible once its request has passed the input and output registers.
// Reset is asynchronous and active low and clears mode, accumulators, counters and halt.
// A result that is not taken stalls parsing; the input register then takes one more
// request and holds it. After an error, requests are accepted but give no result.

module height_map_token_parser_top
  import hmtp_pkg::*;
#(
  parameter int unsigned COLUMN_BITS = COLUMN_BITS_DEF,
  parameter int unsigned ROW_BITS    = ROW_BITS_DEF
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire hmtp_in_t in_req_i,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  output hmtp_out_t     out_req_o
);

  logic       stage_valid;
  hmtp_in_t   stage_req;
  logic       out_space;
  logic       fire;
  hmtp_step_t step;

  // A held request is parsed once the output register can take its result.
  assign fire = stage_valid && out_space;

  hmtp_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_req_i   (in_req_i),
    .consume_i  (fire),
    .valid_o    (stage_valid),
    .req_o      (stage_req)
  );

  hmtp_core #(
    .COLUMN_BITS (COLUMN_BITS),
    .ROW_BITS    (ROW_BITS)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .req_i  (stage_req),
    .step_o (step)
  );

  hmtp_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (fire),
    .step_i      (step),
    .space_o     (out_space),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_req_o   (out_req_o)
  );

endmodule

`default_nettype wire

/* rtl/hmtp_in_reg.sv */
`timescale 1ns / 1ps
`default_nettype none

module hmtp_in_reg
  import hmtp_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire hmtp_in_t in_req_i,
  input  wire logic     consume_i,
  output logic          valid_o,
  output hmtp_in_t      req_o
);

  logic     valid_q;
  hmtp_in_t req_q;

  // The stage takes a new request when empty or when its request leaves.
  assign in_ready_o = !valid_q || consume_i;
  assign valid_o    = valid_q;
  assign req_o      = req_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      req_q <= in_req_i;
    end
  end

endmodule

`default_nettype wire

/* rtl/hmtp_core.sv */
`timescale 1ns / 1ps
`default_nettype none

module hmtp_core
  import hmtp_pkg::*;
#(
  parameter int unsigned COLUMN_BITS = COLUMN_BITS_DEF,
  parameter int unsigned ROW_BITS    = ROW_BITS_DEF
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     fire_i,
  input  wire hmtp_in_t req_i,
  output hmtp_step_t    step_o
);

  hmtp_mode_e             mode_q, mode_d;
  logic [31:0]            val_q, val_d;
  logic                   neg_q, neg_d;
  logic [31:0]            hex_q, hex_d;
  logic [COLUMN_BITS-1:0] col_q, col_d;
  logic [ROW_BITS-1:0]    row_q, row_d;
  logic                   halt_q, halt_d;

  logic       eol, space, digit, minus;
  logic [4:0] hexd;
  logic       do_point, pt_colour, pt_err, do_err, do_line;

  assign eol   = (req_i.operation == OP_EOL);
  assign space = (req_i.ch == CH_SPACE) || (req_i.ch >= CH_TAB && req_i.ch <= CH_CR);
  assign digit = (req_i.ch >= CH_ZERO) && (req_i.ch <= CH_NINE);
  assign minus = (req_i.ch == CH_MINUS);
  assign hexd  = hex_decode(req_i.ch);

  always_comb begin
    mode_d    = mode_q;
    val_d     = val_q;
    neg_d     = neg_q;
    hex_d     = hex_q;
    do_point  = 1'b0;
    pt_colour = 1'b0;
    pt_err    = 1'b0;
    do_err    = 1'b0;
    do_line   = 1'b0;

    if (!halt_q) begin
      case (mode_q)
        MODE_NUMBER: begin
          if (eol) begin
            do_point = 1'b1;
            do_line  = 1'b1;
          end else if (digit) begin
            val_d = (val_q << 3) + (val_q << 1) + {28'd0, req_i.ch[3:0]};
          end else if (space) begin
            do_point = 1'b1;
            mode_d   = MODE_BETWEEN;
          end else if (minus) begin
            do_point = 1'b1;
            mode_d   = MODE_SKIP;
          end else if (req_i.ch == CH_COMMA) begin
            mode_d = MODE_COMMA;
          end else begin
            do_point = 1'b1;
            pt_err   = 1'b1;
          end
        end
        MODE_COMMA: begin
          if (!eol && req_i.ch == CH_ZERO) begin
            mode_d = MODE_ZERO;
          end else begin
            do_point = 1'b1;
            pt_err   = 1'b1;
          end
        end
        MODE_ZERO: begin
          if (!eol && req_i.ch == CH_LOW_X) begin
            hex_d  = '0;
            mode_d = MODE_HEX;
          end else begin
            do_point = 1'b1;
            pt_err   = 1'b1;
          end
        end
        MODE_HEX: begin
          if (eol) begin
            do_point  = 1'b1;
            pt_colour = 1'b1;
            do_line   = 1'b1;
          end else if (hexd[4]) begin
            hex_d = {hex_q[27:0], hexd[3:0]};
          end else if (space) begin
            do_point  = 1'b1;
            pt_colour = 1'b1;
            mode_d    = MODE_BETWEEN;
          end else begin
            do_err = 1'b1;
          end
        end
        MODE_SKIP: begin
          if (eol) begin
            do_line = 1'b1;
          end else if (digit || minus) begin
            mode_d = MODE_SKIP;
          end else if (space) begin
            mode_d = MODE_BETWEEN;
          end else begin
            do_err = 1'b1;
          end
        end
        default: begin
          if (eol) begin
            do_line = 1'b1;
          end else if (space) begin
            mode_d = MODE_BETWEEN;
          end else if (digit || minus) begin
            val_d  = digit ? {28'd0, req_i.ch[3:0]} : 32'd0;
            neg_d  = minus;
            hex_d  = '0;
            mode_d = MODE_NUMBER;
          end else begin
            do_err = 1'b1;
          end
        end
      endcase
    end

    if (do_line) begin
      mode_d = MODE_BETWEEN;
    end
  end

  always_comb begin
    col_d  = col_q;
    row_d  = row_q;
    halt_d = halt_q || pt_err || do_err;
    if (do_point) begin
      col_d = col_q + 1'b1;
    end
    if (do_line) begin
      col_d = '0;
      row_d = row_q + 1'b1;
    end
  end

  always_comb begin
    step_o        = '0;
    step_o.emit   = do_point || do_err;
    if (do_point) begin
      step_o.result.point_valid = 1'b1;
      step_o.result.col         = POS_W'(col_q);
      step_o.result.row         = POS_W'(row_q);
      step_o.result.height      = neg_q ? (32'd0 - val_q) : val_q;
      step_o.result.colour      = pt_colour ? hex_q : 32'd0;
      step_o.result.has_colour  = pt_colour;
      step_o.result.error       = pt_err;
    end else if (do_err) begin
      step_o.result.error = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_BETWEEN;
      val_q  <= '0;
      neg_q  <= 1'b0;
      hex_q  <= '0;
      col_q  <= '0;
      row_q  <= '0;
      halt_q <= 1'b0;
    end else if (fire_i) begin
      mode_q <= mode_d;
      val_q  <= val_d;
      neg_q  <= neg_d;
      hex_q  <= hex_d;
      col_q  <= col_d;
      row_q  <= row_d;
      halt_q <= halt_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halt_q |=> halt_q)
    else $error("parser left the halted state");

  a_no_result_halted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && halt_q) |-> !step_o.emit)
    else $error("result produced while halted");

  a_error_halts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && step_o.emit && step_o.result.error) |=> halt_q)
    else $error("error result did not halt the parser");

  a_eol_col_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && !halt_q && req_i.operation == OP_EOL &&
     mode_q != MODE_COMMA && mode_q != MODE_ZERO) |=> (col_q == '0))
    else $error("column count not cleared at end of line");
`endif

endmodule

`default_nettype wire

/* rtl/hmtp_out_reg.sv */
`timescale 1ns / 1ps
`default_nettype none

module hmtp_out_reg
  import hmtp_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       load_i,
  input  wire hmtp_step_t step_i,
  output logic            space_o,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output hmtp_out_t       out_req_o
);

  logic      valid_q;
  hmtp_out_t req_q;

  // Free when empty or when the held result is taken in this cycle.
  assign space_o     = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_req_o   = req_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (space_o) begin
      valid_q <= load_i && step_i.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (space_o && load_i && step_i.emit) begin
      req_q <= step_i.result;
    end
  end

endmodule

`default_nettype wire

/* tb/tb.sv */
`timescale 1ns / 1ps

module tb;
  import hmtp_pkg::*;

  // Run limits. The slowest correct run stays well below the cycle limit even with
  // every result meeting the longest receiver stall and every request the longest gap.
  localparam int unsigned CYCLE_LIMIT  = 2_000_000;
  localparam int unsigned DRAIN_CYCLES = 12;
  localparam int unsigned RANDOM_ITEMS = 920;

  // Whitespace bytes that the package does not name.
  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_VT = 8'h0B;
  localparam logic [7:0] CH_FF = 8'h0C;

  // Kinds of broken input used to end the run. Any error halts the parser for good,
  // and reset is applied only once, so exactly one of them closes the stimulus.
  typedef enum int {
    BREAK_TOKEN_START,
    BREAK_AFTER_NUMBER,
    BREAK_AFTER_SKIP,
    BREAK_COMMA,
    BREAK_ZERO,
    BREAK_HEX_TAIL,
    BREAK_ZERO_BYTE,
    BREAK_EOL_COMMA,
    BREAK_EOL_ZERO
  } break_kind_e;

  // One row of the request script. A row may carry a hand-written expected point;
  // all other rows are checked against the parser model below.
  typedef struct {
    hmtp_in_t  req;
    bit        typed;
    hmtp_out_t want;
  } script_row_t;

  logic      clk_i;
  logic      rst_ni    = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  hmtp_in_t  in_req    = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  hmtp_out_t out_req;

  // Side-band copy of the script row currently offered on the request channel.
  bit        row_typed = 1'b0;
  hmtp_out_t row_want  = '0;

  script_row_t byte_script[$];
  hmtp_out_t   pending_points[$];
  int          script_pos  = 0;
  int          mismatches  = 0;
  int unsigned cycle_count = 0;

  // Parser model state.
  hmtp_mode_e  pm_mode;
  logic [31:0] pm_value;
  logic        pm_neg;
  logic [31:0] pm_colour;
  logic [11:0] pm_col;
  logic [11:0] pm_row;
  logic        pm_halted;

  height_map_token_parser_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_req_i    (in_req),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_req_o   (out_req)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Parser model
  // ---------------------------------------------------------------------------

  // Builds the point for the token just finished, advances the column and, on an error, halts the model.
  function automatic hmtp_out_t finish_point(input bit with_colour, input bit err);
    hmtp_out_t p;
    p.point_valid = 1'b1;
    p.col         = pm_col;
    p.row         = pm_row;
    p.height      = pm_neg ? (32'd0 - pm_value) : pm_value;
    p.colour      = with_colour ? pm_colour : 32'd0;
    p.has_colour  = with_colour;
    p.error       = err;
    pm_col = pm_col + 12'd1;
    if (err) begin
      pm_halted = 1'b1;
    end
    return p;
  endfunction

  function automatic void start_line();
    pm_row  = pm_row + 12'd1;
    pm_col  = '0;
    pm_mode = MODE_BETWEEN;
  endfunction

  // An error with no point clears every other field.
  function automatic hmtp_out_t halt_bare();
    hmtp_out_t p;
    p = '0;
    p.error = 1'b1;
    pm_halted = 1'b1;
    return p;
  endfunction

  // Returns 1 and the digit value when c is a hex digit in either case.
  function automatic bit hex_nibble(input logic [7:0] c, output logic [3:0] v);
    v = '0;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      v = 4'(c - CH_ZERO);
      return 1'b1;
    end
    if (c >= CH_LOW_A && c <= CH_LOW_F) begin
      v = 4'(c - CH_LOW_A + 8'd10);
      return 1'b1;
    end
    if (c >= CH_UP_A && c <= CH_UP_F) begin
      v = 4'(c - CH_UP_A + 8'd10);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Advances the model by one request; returns 1 when a point or error comes out.
  function automatic bit parse_byte(input hmtp_in_t req, output hmtp_out_t res);
    logic [7:0] c;
    logic [3:0] nib;
    bit         eol;
    bit         space;
    bit         digit;
    bit         is_hex;
    bit         emit;
    c      = req.ch;
    eol    = (req.operation == OP_EOL);
    space  = (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    digit  = (c >= CH_ZERO) && (c <= CH_NINE);
    is_hex = hex_nibble(c, nib);
    res    = '0;
    emit   = 1'b0;
    if (pm_halted) begin
      return 1'b0;
    end
    case (pm_mode)
      MODE_NUMBER: begin
        emit = 1'b1;
        if (eol) begin
          res = finish_point(1'b0, 1'b0);
          start_line();
        end else if (digit) begin
          pm_value = pm_value * 32'd10 + (c - CH_ZERO);
          emit = 1'b0;
        end else if (space) begin
          res = finish_point(1'b0, 1'b0);
          pm_mode = MODE_BETWEEN;
        end else if (c == CH_MINUS) begin
          res = finish_point(1'b0, 1'b0);
          pm_mode = MODE_SKIP;
        end else if (c == CH_COMMA) begin
          pm_mode = MODE_COMMA;
          emit = 1'b0;
        end else begin
          res = finish_point(1'b0, 1'b1);
        end
      end
      MODE_COMMA: begin
        if (!eol && c == CH_ZERO) begin
          pm_mode = MODE_ZERO;
        end else begin
          res = finish_point(1'b0, 1'b1);
          emit = 1'b1;
        end
      end
      MODE_ZERO: begin
        if (!eol && c == CH_LOW_X) begin
          pm_colour = '0;
          pm_mode = MODE_HEX;
        end else begin
          res = finish_point(1'b0, 1'b1);
          emit = 1'b1;
        end
      end
      MODE_HEX: begin
        emit = 1'b1;
        if (eol) begin
          res = finish_point(1'b1, 1'b0);
          start_line();
        end else if (is_hex) begin
          pm_colour = {pm_colour[27:0], nib};
          emit = 1'b0;
        end else if (space) begin
          res = finish_point(1'b1, 1'b0);
          pm_mode = MODE_BETWEEN;
        end else begin
          res = halt_bare();
        end
      end
      MODE_SKIP: begin
        if (eol) begin
          start_line();
        end else if (space) begin
          pm_mode = MODE_BETWEEN;
        end else if (!digit && c != CH_MINUS) begin
          res = halt_bare();
          emit = 1'b1;
        end
      end
      default: begin
        if (eol) begin
          start_line();
        end else if (digit || c == CH_MINUS) begin
          pm_value  = digit ? {24'd0, c - CH_ZERO} : 32'd0;
          pm_neg    = (c == CH_MINUS);
          pm_colour = '0;
          pm_mode   = MODE_NUMBER;
        end else if (!space) begin
          res = halt_bare();
          emit = 1'b1;
        end
      end
    endcase
    return emit;
  endfunction

  // ---------------------------------------------------------------------------
  // Script construction
  // ---------------------------------------------------------------------------

  function automatic hmtp_out_t point_at(input int col, input int row,
                                         input logic [31:0] height,
                                         input logic [31:0] colour, input bit has_colour);
    hmtp_out_t p;
    p.point_valid = 1'b1;
    p.col         = POS_W'(col);
    p.row         = POS_W'(row);
    p.height      = height;
    p.colour      = colour;
    p.has_colour  = has_colour;
    p.error       = 1'b0;
    return p;
  endfunction

  task automatic add_row(input hmtp_op_e op, input logic [7:0] ch);
    script_row_t r;
    r.req.operation = op;
    r.req.ch        = ch;
    r.typed         = 1'b0;
    r.want          = '0;
    byte_script.push_back(r);
  endtask

  task automatic add_checked(input hmtp_op_e op, input logic [7:0] ch,
                             input hmtp_out_t want);
    script_row_t r;
    r.req.operation = op;
    r.req.ch        = ch;
    r.typed         = 1'b1;
    r.want          = want;
    byte_script.push_back(r);
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      add_row(OP_CHAR, s[i]);
    end
  endtask

  // End of line with a random byte riding along; the parser must ignore it.
  task automatic add_eol();
    add_row(OP_EOL, 8'($urandom_range(0, 255)));
  endtask

  function automatic logic [7:0] space_byte();
    int unsigned k;
    k = $urandom_range(8, 13);
    return (k == 8) ? CH_SPACE : 8'(k);
  endfunction

  function automatic logic [7:0] digit_byte();
    return CH_ZERO + 8'($urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] hex_byte();
    int unsigned k;
    k = $urandom_range(0, 21);
    if (k < 10) begin
      return CH_ZERO + 8'(k);
    end
    if (k < 16) begin
      return CH_LOW_A + 8'(k - 10);
    end
    return CH_UP_A + 8'(k - 16);
  endfunction

  // A byte that breaks the grammar at the point named by kind.
  function automatic logic [7:0] odd_byte(input break_kind_e kind);
    logic [7:0] c;
    logic [3:0] nib;
    bit         space;
    bit         digit;
    bit         ok;
    forever begin
      c     = 8'($urandom_range(0, 255));
      space = (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
      digit = (c >= CH_ZERO) && (c <= CH_NINE);
      case (kind)
        BREAK_AFTER_NUMBER: ok = !space && !digit && c != CH_MINUS && c != CH_COMMA;
        BREAK_COMMA:        ok = (c != CH_ZERO);
        BREAK_ZERO:         ok = (c != CH_LOW_X);
        BREAK_HEX_TAIL:     ok = !space && !hex_nibble(c, nib);
        default:            ok = !space && !digit && c != CH_MINUS;
      endcase
      if (ok) begin
        return c;
      end
    end
  endfunction

  // One well-formed token with random content.
  task automatic add_token();
    int unsigned pick;
    int unsigned ndig;
    bit          neg;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      // Height and colour extremes, wrap-around and the sign-only token.
      case (pick)
        0: add_text("2147483647");
        1: add_text("-2147483648");
        2: add_text("4294967295");
        3: add_text("-0");
        4: add_text("99999999999999");
        5: add_text("1,0xFFFFFFFF");
        6: add_text("-1,0x00000000");
        default: add_text("-");
      endcase
    end else begin
      neg = ($urandom_range(0, 3) == 0);
      if (neg) begin
        add_row(OP_CHAR, CH_MINUS);
      end
      if ($urandom_range(0, 9) == 0) begin
        ndig = $urandom_range(9, 14);
      end else begin
        ndig = $urandom_range(neg ? 0 : 1, 4);
      end
      repeat (ndig) add_row(OP_CHAR, digit_byte());
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        add_text(",0x");
        if ($urandom_range(0, 7) == 0) begin
          repeat ($urandom_range(9, 12)) add_row(OP_CHAR, hex_byte());
        end else begin
          repeat ($urandom_range(0, 8)) add_row(OP_CHAR, hex_byte());
        end
      end else if (pick < 45) begin
        // Minus after the number: the rest of the token is skipped.
        add_row(OP_CHAR, CH_MINUS);
        repeat ($urandom_range(0, 4)) begin
          add_row(OP_CHAR, ($urandom_range(0, 2) == 0) ? CH_MINUS : digit_byte());
        end
      end
    end
  endtask

  task automatic add_separator();
    int unsigned k;
    k = $urandom_range(0, 9);
    if (k < 2) begin
      add_eol();
    end else begin
      repeat ($urandom_range(1, 3)) add_row(OP_CHAR, space_byte());
      if (k == 9) begin
        repeat ($urandom_range(1, 2)) add_eol();
      end
    end
  endtask

  // Ends the script with one randomly chosen grammar error, then noise that the
  // halted parser must swallow without a result.
  task automatic add_break_and_noise();
    break_kind_e kind;
    kind = break_kind_e'($urandom_range(0, 8));
    add_row(OP_CHAR, CH_SPACE);
    case (kind)
      BREAK_TOKEN_START: add_row(OP_CHAR, odd_byte(kind));
      BREAK_AFTER_NUMBER: begin
        add_text("42");
        add_row(OP_CHAR, odd_byte(kind));
      end
      BREAK_AFTER_SKIP: begin
        add_text("-6-1");
        add_row(OP_CHAR, odd_byte(kind));
      end
      BREAK_COMMA: begin
        add_text("13,");
        add_row(OP_CHAR, odd_byte(kind));
      end
      BREAK_ZERO: begin
        add_text("13,0");
        add_row(OP_CHAR, odd_byte(kind));
      end
      BREAK_HEX_TAIL: begin
        add_text("8,0xA");
        add_row(OP_CHAR, odd_byte(kind));
      end
      BREAK_ZERO_BYTE: add_row(OP_CHAR, 8'h00);
      BREAK_EOL_COMMA: begin
        add_text("77,");
        add_eol();
      end
      default: begin
        add_text("77,0");
        add_eol();
      end
    endcase
    add_text("1 2 ");
    add_row(OP_CHAR, 8'hFF);
    add_row(OP_CHAR, 8'h00);
    repeat (40) begin
      add_row(hmtp_op_e'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Request side: bursts of random length separated by random gaps. A third of
  // the bursts are followed by no gap at all, so long unbroken runs also occur.
  // ---------------------------------------------------------------------------
  int burst_left = 1;
  int gap_left   = 0;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      // The offered request, if any, was taken at this edge.
      if (in_valid) begin
        script_pos++;
      end
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (script_pos < byte_script.size()) begin
        in_valid  <= 1'b1;
        in_req    <= byte_script[script_pos].req;
        row_typed <= byte_script[script_pos].typed;
        row_want  <= byte_script[script_pos].want;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 40);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 9);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result side: the receiver switches between always ready, random stalls and a
  // rotating stall pattern. The pattern always has a ready bit, so stalls stay short.
  // ---------------------------------------------------------------------------
  int         stall_mode    = 0;
  int         stall_left    = 0;
  logic [7:0] stall_pattern = 8'hFF;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (stall_left == 0) begin
        stall_mode    = $urandom_range(0, 2);
        stall_left    = $urandom_range(20, 300);
        stall_pattern = 8'($urandom) | 8'h01;
      end else begin
        stall_left--;
      end
      case (stall_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(0, 3) != 0);
        default: begin
          out_ready <= stall_pattern[0];
          stall_pattern = {stall_pattern[0], stall_pattern[7:1]};
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Scoreboard: every accepted request runs through the parser model, and every
  // accepted result is compared with the oldest pending point.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : scoreboard
    hmtp_out_t predicted;
    hmtp_out_t want;
    bit        emits;
    if (rst_ni) begin
      if (out_valid && out_ready) begin
        if (pending_points.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result: v=%0b col=%0d row=%0d h=%0d c=%h hc=%0b e=%0b",
                   $time, out_req.point_valid, out_req.col, out_req.row, out_req.height,
                   out_req.colour, out_req.has_colour, out_req.error);
        end else begin
          want = pending_points.pop_front();
          if (out_req.point_valid !== want.point_valid || out_req.col !== want.col ||
              out_req.row !== want.row || out_req.height !== want.height ||
              out_req.colour !== want.colour || out_req.has_colour !== want.has_colour ||
              out_req.error !== want.error) begin
            mismatches++;
            $display("%0t: point mismatch: expected v=%0b col=%0d row=%0d h=%0d c=%h hc=%0b e=%0b",
                     $time, want.point_valid, want.col, want.row, want.height,
                     want.colour, want.has_colour, want.error);
            $display("%0t:                 actual   v=%0b col=%0d row=%0d h=%0d c=%h hc=%0b e=%0b",
                     $time, out_req.point_valid, out_req.col, out_req.row, out_req.height,
                     out_req.colour, out_req.has_colour, out_req.error);
          end
        end
      end
      if (in_valid && in_ready) begin
        emits = parse_byte(in_req, predicted);
        if (emits) begin
          pending_points.push_back(row_typed ? row_want : predicted);
        end
      end
    end
  end

  // Watchdog against a hang.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d points still pending",
               $time, cycle_count, pending_points.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence: build the script, reset, let it drain, then report.
  // ---------------------------------------------------------------------------
  initial begin : run
    int base;

    pm_mode   = MODE_BETWEEN;
    pm_value  = '0;
    pm_neg    = 1'b0;
    pm_colour = '0;
    pm_col    = '0;
    pm_row    = '0;
    pm_halted = 1'b0;

    // Directed rows. The points that follow straight from the grammar are written
    // out by hand: a zero token, the sign-only token, an upper and lower case
    // colour, an empty colour closed by end of line, and minus after a number
    // with the skipped tail behind it.
    add_row(OP_CHAR, CH_ZERO);
    add_checked(OP_CHAR, CH_SPACE, point_at(0, 0, 32'd0, 32'd0, 1'b0));
    add_row(OP_CHAR, CH_MINUS);
    add_checked(OP_CHAR, CH_TAB, point_at(1, 0, 32'd0, 32'd0, 1'b0));
    add_text("9,0xFf");
    add_checked(OP_CHAR, CH_SPACE, point_at(2, 0, 32'd9, 32'hFF, 1'b1));
    add_text("7,0x");
    add_checked(OP_EOL, 8'hFF, point_at(3, 0, 32'd7, 32'd0, 1'b1));
    add_text("5");
    add_checked(OP_CHAR, CH_MINUS, point_at(0, 1, 32'd5, 32'd0, 1'b0));
    add_text("3-");
    add_row(OP_CHAR, CH_CR);
    add_text("1");
    add_checked(OP_CHAR, CH_VT, point_at(1, 1, 32'd1, 32'd0, 1'b0));
    add_row(OP_EOL, 8'h00);
    add_row(OP_CHAR, CH_FF);
    add_row(OP_CHAR, CH_LF);

    // Random well-formed text.
    base = byte_script.size();
    while (byte_script.size() - base < RANDOM_ITEMS) begin
      add_token();
      add_separator();
    end

    add_break_and_noise();

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    do @(posedge clk_i); while (script_pos < byte_script.size() || in_valid);
    while (pending_points.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
